// ===== rtl/distance_vector_route_table_macros.svh =====
// Assertion helpers for the route table RTL.
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_MACROS_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define DVRT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("route table assertion failed");
`define DVRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("route table assertion failed");
`else
`define DVRT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define DVRT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/dvrt_pkg.sv =====
`default_nettype none

package dvrt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W = 32;
  localparam int COST_W = 16;
  localparam int ENTRY_W = ADDR_W + COST_W;

  localparam logic [COST_W-1:0] UNREACH_RESET = 16'd16;

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_DUMP   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED   = 3'd0,
    ST_LOWERED    = 3'd1,
    ST_KEPT       = 3'd2,
    ST_FULL_DROP  = 3'd3,
    ST_FOUND      = 3'd4,
    ST_MISSING    = 3'd5,
    ST_DUMP_ENTRY = 3'd6,
    ST_DUMP_EMPTY = 3'd7
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_MISS,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] dest_addr;
    logic [COST_W-1:0] route_cost;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] out_addr;
    logic [COST_W-1:0] out_cost;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [COST_W-1:0] cost;
  } entry_t;

  typedef struct packed {
    logic lt;       // stored address below key
    logic eq;       // stored address equals key
    logic cost_gt;  // stored cost above offered cost
  } cmp_t;

endpackage

`default_nettype wire

// ===== rtl/dvrt_ram.sv =====
`default_nettype none

module dvrt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/dvrt_cmp.sv =====
`default_nettype none

module dvrt_cmp (
  input  wire dvrt_pkg::entry_t                  slot,
  input  wire logic [dvrt_pkg::ADDR_W-1:0]       key_addr,
  input  wire logic [dvrt_pkg::COST_W-1:0]       key_cost,
  output dvrt_pkg::cmp_t                         flags
);

  import dvrt_pkg::*;

  always_comb begin
    flags.lt      = slot.addr < key_addr;
    flags.eq      = slot.addr == key_addr;
    flags.cost_gt = slot.cost > key_cost;
  end

endmodule

`default_nettype wire

// ===== rtl/distance_vector_route_table.sv =====
// Sorted route table, up to 32 entries, held in a one-read one-write memory
// with registered read data and walked by a small sequencer. busy is high
// from the cycle after start is taken until the last result appears on
// result; a new start can be taken in the cycle that result is shown.
// Update and query scan linearly from the lowest address, reading then
// comparing each entry passed, and then decide; an insert then moves each
// higher entry up one slot with a read and a write per entry and writes the
// new one in a final step. A dump reads and then shows each entry in turn.
// The memory's single read port sets this pacing. Every result is shown on
// result for exactly one cycle with result_valid high; the receiver cannot
// stall, so it must take each word as it comes. No clearing pass follows
// reset: slots beyond the entry count are never used.
`default_nettype none
`include "distance_vector_route_table_macros.svh"

module distance_vector_route_table (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire dvrt_pkg::req_t                req,
  output logic                               result_valid,
  output dvrt_pkg::res_t                     result,
  input  wire logic                          cfg_we,
  input  wire logic [dvrt_pkg::COST_W-1:0]   cfg_wdata
);

  import dvrt_pkg::*;

  state_e state, state_next;
  req_t   req_q;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] sp, sp_next;
  logic [CNT_W-1:0] sp_m1;
  logic [CNT_W-1:0] idx_p1;
  logic [COST_W-1:0] unreach_cost;
  res_t res_next;
  logic res_valid_next;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t           slot;
  cmp_t             flags;
  logic             accept;
  logic             full;

  assign accept = start && !busy;
  assign busy   = state != S_IDLE;
  assign slot   = entry_t'(ram_rdata);
  assign sp_m1  = sp - 1'b1;
  assign idx_p1 = idx + 1'b1;
  assign full   = count == CNT_W'(TABLE_DEPTH);

  dvrt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dvrt_cmp u_cmp (
    .slot     (slot),
    .key_addr (req_q.dest_addr),
    .key_cost (req_q.route_cost),
    .flags    (flags)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority case (req.cmd)
            CMD_UPDATE, CMD_QUERY: state_next = S_SRCH_RD;
            CMD_DUMP:              state_next = S_DUMP_RD;
            default:               state_next = S_IDLE;
          endcase
        end
      end
      S_SRCH_RD: begin
        state_next = (idx == count) ? S_MISS : S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        priority if (flags.lt) state_next = S_SRCH_RD;
        else if (flags.eq)     state_next = S_IDLE;
        else                   state_next = S_MISS;
      end
      S_MISS: begin
        priority if (req_q.cmd == CMD_QUERY || full) state_next = S_IDLE;
        else if (count != idx)                       state_next = S_SHIFT_RD;
        else                                         state_next = S_INSERT;
      end
      S_SHIFT_RD: state_next = S_SHIFT_WR;
      S_SHIFT_WR: state_next = (sp_m1 == idx) ? S_INSERT : S_SHIFT_RD;
      S_INSERT:   state_next = S_IDLE;
      S_DUMP_RD:  state_next = (count == '0) ? S_IDLE : S_DUMP_OUT;
      S_DUMP_OUT: state_next = (idx_p1 == count) ? S_IDLE : S_DUMP_RD;
      default:    state_next = S_IDLE;
    endcase
  end

  // datapath controls and result word
  always_comb begin
    ram_we         = 1'b0;
    ram_waddr      = idx[IDX_W-1:0];
    ram_wdata      = '{addr: req_q.dest_addr, cost: req_q.route_cost};
    ram_raddr      = idx[IDX_W-1:0];
    idx_next       = idx;
    sp_next        = sp;
    count_next     = count;
    res_valid_next = 1'b0;
    res_next       = result;
    unique case (state)
      S_IDLE: begin
        idx_next = '0;
      end
      S_SRCH_RD: begin
        ram_raddr = idx[IDX_W-1:0];
      end
      S_SRCH_CMP: begin
        priority if (flags.lt) begin
          idx_next = idx_p1;
        end else if (flags.eq) begin
          res_valid_next = 1'b1;
          res_next.out_addr = req_q.dest_addr;
          res_next.last     = 1'b1;
          priority if (req_q.cmd == CMD_QUERY) begin
            res_next.status   = ST_FOUND;
            res_next.out_cost = slot.cost;
          end else if (flags.cost_gt) begin
            ram_we            = 1'b1;
            res_next.status   = ST_LOWERED;
            res_next.out_cost = req_q.route_cost;
          end else begin
            res_next.status   = ST_KEPT;
            res_next.out_cost = slot.cost;
          end
        end
      end
      S_MISS: begin
        sp_next = count;
        priority if (req_q.cmd == CMD_QUERY) begin
          res_valid_next    = 1'b1;
          res_next.status   = ST_MISSING;
          res_next.out_addr = req_q.dest_addr;
          res_next.out_cost = unreach_cost;
          res_next.last     = 1'b1;
        end else if (full) begin
          res_valid_next    = 1'b1;
          res_next.status   = ST_FULL_DROP;
          res_next.out_addr = req_q.dest_addr;
          res_next.out_cost = req_q.route_cost;
          res_next.last     = 1'b1;
        end
      end
      S_SHIFT_RD: begin
        ram_raddr = sp_m1[IDX_W-1:0];
      end
      S_SHIFT_WR: begin
        // move the entry just read up by one slot
        ram_we    = 1'b1;
        ram_waddr = sp[IDX_W-1:0];
        ram_wdata = slot;
        sp_next   = sp_m1;
      end
      S_INSERT: begin
        ram_we            = 1'b1;
        count_next        = count + 1'b1;
        res_valid_next    = 1'b1;
        res_next.status   = ST_INSERTED;
        res_next.out_addr = req_q.dest_addr;
        res_next.out_cost = req_q.route_cost;
        res_next.last     = 1'b1;
      end
      S_DUMP_RD: begin
        ram_raddr = idx[IDX_W-1:0];
        if (count == '0) begin
          res_valid_next    = 1'b1;
          res_next.status   = ST_DUMP_EMPTY;
          res_next.out_addr = '0;
          res_next.out_cost = '0;
          res_next.last     = 1'b1;
        end
      end
      S_DUMP_OUT: begin
        idx_next          = idx_p1;
        res_valid_next    = 1'b1;
        res_next.status   = ST_DUMP_ENTRY;
        res_next.out_addr = slot.addr;
        res_next.out_cost = slot.cost;
        res_next.last     = idx_p1 == count;
      end
      default: begin
        idx_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
      unreach_cost <= UNREACH_RESET;
    end else begin
      state        <= state_next;
      count        <= count_next;
      result_valid <= res_valid_next;
      if (cfg_we) begin
        unreach_cost <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    idx    <= idx_next;
    sp     <= sp_next;
    result <= res_next;
  end

  `DVRT_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(TABLE_DEPTH))
  `DVRT_ASSERT_IMPLY(a_strobe_from_busy, clk, rst, result_valid, $past(busy))
  `DVRT_ASSERT_NEXT(a_no_strobe_after_accept, clk, rst, accept, !result_valid)
  `DVRT_ASSERT_IMPLY(a_count_grows_on_insert, clk, rst, count != $past(count), result_valid && result.status == ST_INSERTED)
  `DVRT_ASSERT_IMPLY(a_search_in_range, clk, rst, state == S_SRCH_CMP, idx < count)

endmodule

`default_nettype wire
